FILE: hdl/bounded_history_table_defines.svh
// Assertion macros for the history table RTL.
`ifndef BOUNDED_HISTORY_TABLE_DEFINES_SVH
`define BOUNDED_HISTORY_TABLE_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define BHT_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("bounded_history_table: invariant violated");

// Consequence that must hold in the cycle after the antecedent.
`define BHT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bounded_history_table: sequence check failed");

`endif

FILE: hdl/bht_pkg.sv
// Types and constants shared by the history table modules.
package bht_pkg;

    localparam int WORD_W  = 64;
    localparam int POS_W   = 4;
    localparam int COUNT_W = 5;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_GET    = 2'd2,
        OP_MARK   = 2'd3
    } op_t;

    typedef struct packed {
        logic [WORD_W-1:0] key;
        logic [WORD_W-1:0] revision;
        logic [WORD_W-1:0] payload;
    } data_t;

    typedef struct packed {
        data_t data;
        logic  delivered;
    } entry_t;

    // Per-cell control for one accepted item.
    typedef struct packed {
        logic add_full;
        logic remove;
        logic load;
        logic mark;
        logic occupied;
    } cell_ctrl_t;

endpackage

FILE: hdl/bht_cmd_if.sv
// Command channel of the history table: valid, ready and the command fields.
interface bht_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   op;
    logic [bht_pkg::WORD_W-1:0]   session_key;
    logic [bht_pkg::WORD_W-1:0]   revision;
    logic [bht_pkg::WORD_W-1:0]   payload;
    logic [bht_pkg::POS_W-1:0]    position;

    modport source (output valid, op, session_key, revision, payload, position,
                    input ready);
    modport sink   (input valid, op, session_key, revision, payload, position,
                    output ready);
endinterface

FILE: hdl/bht_res_if.sv
// Result channel of the history table: valid, ready and the result fields.
interface bht_res_if;
    logic                         valid;
    logic                         ready;
    logic                         ok;
    logic [bht_pkg::WORD_W-1:0]   out_key;
    logic [bht_pkg::WORD_W-1:0]   out_revision;
    logic [bht_pkg::WORD_W-1:0]   out_payload;
    logic                         out_delivered;
    logic [bht_pkg::COUNT_W-1:0]  held_count;

    modport source (output valid, ok, out_key, out_revision, out_payload,
                    out_delivered, held_count, input ready);
    modport sink   (input valid, ok, out_key, out_revision, out_payload,
                    out_delivered, held_count, output ready);
endinterface

FILE: hdl/bounded_history_table.sv
// Top level of the bounded history table: a chain of entry cells and a result register.
//
// The block keeps an ordered history of up to DEPTH entries, oldest at position 0.
// Commands arrive on the cmd channel (op, session_key, revision, payload, position)
// and every command produces exactly one item on the res channel (ok, out_key,
// out_revision, out_payload, out_delivered, held_count). An item is accepted when
// valid and ready are both high at a rising clock edge.
//
// Each command is executed in the cycle it is accepted: all cells compare their
// key and revision in parallel, the first-match signal ripples up the cell chain,
// and every cell either holds, loads the new entry, sets its flag or takes the
// contents of its upper neighbor. The result is registered, so it appears on res
// in the cycle after acceptance. One command per cycle is sustained as long as the
// receiver takes results; the ripple through the DEPTH cells sets the cycle time.
//
// When the receiver stalls, the result stays in the output register and cmd.ready
// drops until it is taken, so no command is lost. Reset empties the table, clears
// every delivered flag and the result valid bit; entry words are not cleared and
// are never read before being written.
`include "bounded_history_table_defines.svh"

module bounded_history_table #(
    parameter int DEPTH = 16
) (
    input  logic    clk,
    input  logic    rst_n,
    bht_cmd_if.sink cmd,
    bht_res_if.source res
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CMP_W = (CNT_W > bht_pkg::COUNT_W) ? CNT_W : bht_pkg::COUNT_W;

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               res_valid_reg;
    logic               res_ok_reg;
    bht_pkg::data_t     res_data_reg;
    logic               res_delivered_reg;
    logic [bht_pkg::COUNT_W-1:0] res_count_reg;

    logic               accept;
    logic               full;
    logic               pos_valid;
    logic [CMP_W-1:0]   pos_ext;
    logic [CMP_W-1:0]   count_ext;
    logic [CMP_W-1:0]   count_next_ext;
    logic [IDX_W-1:0]   rd_idx;
    bht_pkg::op_t       op;
    bht_pkg::data_t     fill;
    logic               found;
    logic               ok_next;
    bht_pkg::data_t     rd_data_next;
    logic               rd_flag_next;

    bht_pkg::entry_t    cell_q [DEPTH];
    bht_pkg::entry_t    upper  [DEPTH];
    bht_pkg::cell_ctrl_t ctrl  [DEPTH];
    logic [DEPTH:0]     match;
    logic [DEPTH-1:0]   occ_vec;
    logic [DEPTH-1:0]   flag_vec;

    // Input side is free whenever the result register is empty or being emptied.
    assign cmd.ready = !res_valid_reg || res.ready;
    assign accept    = cmd.valid && cmd.ready;
    assign op        = bht_pkg::op_t'(cmd.op);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pos_ext   = CMP_W'(cmd.position);
    assign count_ext = CMP_W'(count_reg);
    assign pos_valid = (pos_ext < count_ext);
    assign rd_idx    = pos_ext[IDX_W-1:0];
    assign fill      = '{key: cmd.session_key, revision: cmd.revision,
                         payload: cmd.payload};
    assign match[0]  = 1'b0;
    assign found     = match[DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            // The top cell's upper neighbor is the incoming entry with a clear flag.
            if (gi == DEPTH - 1)
            begin : g_top
                assign upper[gi] = '{data: fill, delivered: 1'b0};
            end
            else
            begin : g_mid
                assign upper[gi] = cell_q[gi+1];
            end

            assign occ_vec[gi]          = (CNT_W'(gi) < count_reg);
            assign flag_vec[gi]         = cell_q[gi].delivered;
            assign ctrl[gi].add_full    = accept && (op == bht_pkg::OP_ADD) && full;
            assign ctrl[gi].remove      = accept && (op == bht_pkg::OP_REMOVE);
            assign ctrl[gi].load        = accept && (op == bht_pkg::OP_ADD) && !full &&
                                          (count_reg == CNT_W'(gi));
            assign ctrl[gi].mark        = accept && (op == bht_pkg::OP_MARK) && pos_valid &&
                                          (pos_ext == CMP_W'(gi));
            assign ctrl[gi].occupied    = occ_vec[gi];

            bht_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl[gi]),
                .key       (cmd.session_key),
                .revision  (cmd.revision),
                .fill      (fill),
                .upper     (upper[gi]),
                .match_in  (match[gi]),
                .match_out (match[gi+1]),
                .entry     (cell_q[gi])
            );
        end
    endgenerate

    // Count update and the result fields of the command being accepted.
    always_comb
    begin
        count_next   = count_reg;
        ok_next      = 1'b0;
        rd_data_next = '0;
        rd_flag_next = 1'b0;
        case (op)
            bht_pkg::OP_ADD:
            begin
                ok_next = 1'b1;
                if (!full)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            bht_pkg::OP_REMOVE:
            begin
                ok_next = found;
                if (found)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            bht_pkg::OP_GET:
            begin
                ok_next = pos_valid;
                if (pos_valid)
                begin
                    rd_data_next = cell_q[rd_idx].data;
                    rd_flag_next = cell_q[rd_idx].delivered;
                end
            end
            bht_pkg::OP_MARK:
            begin
                ok_next = pos_valid;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    assign count_next_ext = CMP_W'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            if (accept)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_ok_reg        <= ok_next;
            res_data_reg      <= rd_data_next;
            res_delivered_reg <= rd_flag_next;
            res_count_reg     <= count_next_ext[bht_pkg::COUNT_W-1:0];
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.ok            = res_ok_reg;
    assign res.out_key       = res_data_reg.key;
    assign res.out_revision  = res_data_reg.revision;
    assign res.out_payload   = res_data_reg.payload;
    assign res.out_delivered = res_delivered_reg;
    assign res.held_count    = res_count_reg;

    // Slots at or above the count never carry a delivered flag.
    `BHT_ASSERT_ALWAYS(a_flags_within_count, (flag_vec & ~occ_vec) == '0)
    `BHT_ASSERT_ALWAYS(a_count_bounded, count_reg <= CNT_W'(DEPTH))
    `BHT_ASSERT_NEXT(a_add_grows, accept && (op == bht_pkg::OP_ADD) && !full,
        count_reg == $past(count_reg) + CNT_W'(1))
    `BHT_ASSERT_NEXT(a_remove_miss_holds, accept && (op == bht_pkg::OP_REMOVE) && !found,
        (count_reg == $past(count_reg)) && !res_ok_reg)
    `BHT_ASSERT_NEXT(a_accept_gives_result, accept, res_valid_reg)

endmodule

FILE: hdl/bht_cell.sv
// One table cell: holds an entry, matches it and takes its upper neighbor on a shift.
module bht_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bht_pkg::cell_ctrl_t         ctrl,
    input  logic [bht_pkg::WORD_W-1:0]  key,
    input  logic [bht_pkg::WORD_W-1:0]  revision,
    input  bht_pkg::data_t              fill,
    input  bht_pkg::entry_t             upper,
    input  logic                        match_in,
    output logic                        match_out,
    output bht_pkg::entry_t             entry
);

    bht_pkg::data_t data_reg;
    bht_pkg::data_t data_next;
    logic           flag_reg;
    logic           flag_next;
    logic           hit;
    logic           shift;

    always_comb
    begin
        hit = ctrl.occupied && (data_reg.key == key) && (data_reg.revision == revision);
        // A removal closes the gap from the first match upward.
        match_out = match_in | hit;
        shift     = ctrl.add_full | (ctrl.remove & match_out);
        data_next = data_reg;
        flag_next = flag_reg;
        if (shift)
        begin
            data_next = upper.data;
            flag_next = upper.delivered;
        end
        else if (ctrl.load)
        begin
            data_next = fill;
            flag_next = 1'b0;
        end
        else if (ctrl.mark)
        begin
            flag_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= 1'b0;
        end
        else
        begin
            flag_reg <= flag_next;
        end
    end

    assign entry = '{data: data_reg, delivered: flag_reg};

endmodule
